// ===== design/yp_pkg.sv =====
// Shared types and constants for the YUY2 video processing amplifier.
package yp_pkg;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_TABLE = 1'b1;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTRAST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COS_HUE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIN_HUE = 3'd4;

	localparam logic [7:0] BRIGHTNESS_RST = 8'd127;
	localparam logic [7:0] CONTRAST_RST = 8'd127;
	localparam logic [7:0] SATURATION_RST = 8'd128;
	localparam logic signed [15:0] COS_HUE_RST = 16'sd16384;
	localparam logic signed [15:0] SIN_HUE_RST = 16'sd0;

	typedef struct packed {
		logic       op;
		logic [7:0] y0;
		logic [7:0] u;
		logic [7:0] y1;
		logic [7:0] v;
		logic [7:0] table_index;
		logic [7:0] table_value;
	} in_t;

	typedef struct packed {
		logic [7:0] y0_out;
		logic [7:0] u_out;
		logic [7:0] y1_out;
		logic [7:0] v_out;
	} out_t;

	typedef struct packed {
		logic [7:0]         brightness;
		logic [7:0]         contrast;
		logic [7:0]         saturation;
		logic signed [15:0] cos_hue;
		logic signed [15:0] sin_hue;
	} cfg_t;

	// Command between front and back: a table write or a pixel whose luma
	// has been reduced to two gamma table addresses.
	typedef struct packed {
		logic       op;
		logic [7:0] a0;
		logic [7:0] a1;
		logic [7:0] u;
		logic [7:0] v;
	} cmd_t;

endpackage

// ===== design/yuy2_procamp.sv =====
// Top level of the YUY2 processing amplifier: registers, front, queue, back.
// Path: a pixel request passes three front stages, one queue slot, one gamma read stage
//   and the result register before it shows on the result ports.
// Throughput: one request per cycle while full is low, pixel or table write; the gamma
//   table has one read port pair and one write port, and each request uses it once.
// Reset: clears all valid flags, queue pointers and the registers to their defaults;
//   the gamma table is not cleared and must be loaded before pixels read it.
module yuy2_procamp #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [yp_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [yp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                           push,
	output logic                           full,
	input  yp_pkg::in_t                    in_item,
	output logic                           empty,
	input  logic                           pop,
	output yp_pkg::out_t                   out_item
);

	yp_pkg::cfg_t cfg_q;
	logic         q_push, q_pop, q_full, q_empty;
	yp_pkg::cmd_t q_wdata, q_rdata;

	// Register file: write only, unknown indexes drop the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness <= yp_pkg::BRIGHTNESS_RST;
			cfg_q.contrast <= yp_pkg::CONTRAST_RST;
			cfg_q.saturation <= yp_pkg::SATURATION_RST;
			cfg_q.cos_hue <= yp_pkg::COS_HUE_RST;
			cfg_q.sin_hue <= yp_pkg::SIN_HUE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				yp_pkg::REG_BRIGHTNESS: cfg_q.brightness <= cfg_wdata[7:0];
				yp_pkg::REG_CONTRAST: cfg_q.contrast <= cfg_wdata[7:0];
				yp_pkg::REG_SATURATION: cfg_q.saturation <= cfg_wdata[7:0];
				yp_pkg::REG_COS_HUE: cfg_q.cos_hue <= $signed(cfg_wdata);
				yp_pkg::REG_SIN_HUE: cfg_q.sin_hue <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Front: take requests, hold the pipeline when the queue backs up.
	yp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	// Queue: absorb stalls so each side can hold on its own.
	yp_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// Back: write the gamma table or look up both lumas, then present the result.
	yp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

	// Never push into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into full queue");

	// Never pop an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command popped from empty queue");

	// Input backpressure comes only from a full queue.
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("input held while queue has room");

endmodule

// ===== design/yp_front.sv =====
// Front end: accept requests, split by kind, compute chroma and luma addresses.
module yp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  yp_pkg::cfg_t  cfg,
	input  logic          push,
	output logic          full,
	input  yp_pkg::in_t   in_item,
	input  logic          q_full,
	output logic          q_push,
	output yp_pkg::cmd_t  q_data
);

	// ceil(2^23 / 127): exact truncating division for magnitudes below 2^16
	localparam logic [16:0] RECIP_127 = 17'd66053;
	localparam int RECIP_SHIFT = 23;

	function automatic logic [7:0] clamp8(input logic signed [13:0] x);
		logic [7:0] r;
		if (x < 14'sd0) r = 8'd0;
		else if (x > 14'sd255) r = 8'd255;
		else r = x[7:0];
		return r;
	endfunction

	logic en;
	logic v1_q, v2_q, v3_q;

	yp_pkg::in_t in_s1;

	logic               op_s2;
	logic [7:0]         ti_s2, tv_s2;
	logic signed [23:0] pcu_s2, pvs_s2, pvc_s2, pus_s2;
	logic signed [17:0] x0_s2, x1_s2;

	logic               op_s3;
	logic [7:0]         ti_s3, tv_s3;
	logic signed [31:0] numu_s3, numv_s3;
	logic [8:0]         q0_s3, q1_s3;
	logic               n0_s3, n1_s3;

	logic signed [7:0]  uc, vc;
	logic signed [8:0]  d0, d1;
	logic signed [8:0]  gain;
	logic signed [24:0] su, sv;
	logic signed [6:0]  sat4;
	logic [16:0]        mag0, mag1;
	logic [17:0]        neg0, neg1;
	logic [33:0]        prod0, prod1;
	logic signed [13:0] cu, cv;
	logic signed [13:0] l0, l1;
	logic signed [13:0] g0, g1;

	assign en = !v3_q || !q_full;
	assign full = !en;
	assign q_push = v3_q && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else if (en) begin
			v1_q <= push;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	// stage 1: capture the request
	always_ff @(posedge clk) begin
		if (en) in_s1 <= in_item;
	end

	// stage 2: chroma rotation products and luma gain
	assign uc = {~in_s1.u[7], in_s1.u[6:0]};
	assign vc = {~in_s1.v[7], in_s1.v[6:0]};
	assign d0 = $signed({1'b0, in_s1.y0} - 9'd16);
	assign d1 = $signed({1'b0, in_s1.y1} - 9'd16);
	assign gain = $signed({1'b0, cfg.contrast});

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= in_s1.op;
			ti_s2  <= in_s1.table_index;
			tv_s2  <= in_s1.table_value;
			pcu_s2 <= uc * cfg.cos_hue;
			pvs_s2 <= vc * cfg.sin_hue;
			pvc_s2 <= vc * cfg.cos_hue;
			pus_s2 <= uc * cfg.sin_hue;
			x0_s2  <= d0 * gain;
			x1_s2  <= d1 * gain;
		end
	end

	// stage 3: saturation scaling and division of the luma gain by 127
	assign su = {pcu_s2[23], pcu_s2} + {pvs_s2[23], pvs_s2};
	assign sv = {pvc_s2[23], pvc_s2} - {pus_s2[23], pus_s2};
	assign sat4 = $signed({1'b0, cfg.saturation[7:2]});
	assign neg0 = 18'd0 - x0_s2;
	assign neg1 = 18'd0 - x1_s2;
	assign mag0 = x0_s2[17] ? neg0[16:0] : x0_s2[16:0];
	assign mag1 = x1_s2[17] ? neg1[16:0] : x1_s2[16:0];
	assign prod0 = mag0 * RECIP_127;
	assign prod1 = mag1 * RECIP_127;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3   <= op_s2;
			ti_s3   <= ti_s2;
			tv_s3   <= tv_s2;
			numu_s3 <= su * sat4;
			numv_s3 <= sv * sat4;
			q0_s3   <= prod0[RECIP_SHIFT+8:RECIP_SHIFT];
			q1_s3   <= prod1[RECIP_SHIFT+8:RECIP_SHIFT];
			n0_s3   <= x0_s2[17];
			n1_s3   <= x1_s2[17];
		end
	end

	// floor by arithmetic shift, recenter, clamp; luma offset and clamp to an address
	assign cu = {numu_s3[31], numu_s3[31:19]} + 14'sd128;
	assign cv = {numv_s3[31], numv_s3[31:19]} + 14'sd128;
	assign g0 = n0_s3 ? -$signed({5'd0, q0_s3}) : $signed({5'd0, q0_s3});
	assign g1 = n1_s3 ? -$signed({5'd0, q1_s3}) : $signed({5'd0, q1_s3});
	assign l0 = g0 + $signed({6'd0, cfg.brightness}) - 14'sd111;
	assign l1 = g1 + $signed({6'd0, cfg.brightness}) - 14'sd111;

	always_comb begin
		q_data.op = op_s3;
		if (op_s3 == yp_pkg::OP_TABLE) begin
			q_data.a0 = ti_s3;
			q_data.a1 = tv_s3;
		end else begin
			q_data.a0 = clamp8(l0);
			q_data.a1 = clamp8(l1);
		end
		q_data.u = clamp8(cu);
		q_data.v = clamp8(cv);
	end

endmodule

// ===== design/yp_cmd_fifo.sv =====
// Short command queue between the front and back ends.
module yp_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  yp_pkg::cmd_t wdata,
	output logic         full,
	input  logic         pop,
	output yp_pkg::cmd_t rdata,
	output logic         empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	yp_pkg::cmd_t       mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push, do_pop;

	assign full = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== design/yp_back.sv =====
// Back end: gamma table writes and lookups, result register.
module yp_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_empty,
	input  yp_pkg::cmd_t q_data,
	output logic         q_pop,
	output logic         empty,
	input  logic         pop,
	output yp_pkg::out_t out_item
);

	logic [7:0] gamma_mem [256];

	logic       rd_v_s1;
	logic [7:0] g0_s1, g1_s1, u_s1, v_s1;
	logic       out_v_q;
	logic       adv, take_pix, take_tbl;

	assign adv = !out_v_q || pop;
	assign q_pop = !q_empty && (!rd_v_s1 || adv);
	assign take_pix = q_pop && (q_data.op == yp_pkg::OP_PIXEL);
	assign take_tbl = q_pop && (q_data.op == yp_pkg::OP_TABLE);
	assign empty = !out_v_q;

	always_ff @(posedge clk) begin
		if (take_tbl) gamma_mem[q_data.a0] <= q_data.a1;
	end

	always_ff @(posedge clk) begin
		if (take_pix) begin
			g0_s1 <= gamma_mem[q_data.a0];
			g1_s1 <= gamma_mem[q_data.a1];
			u_s1 <= q_data.u;
			v_s1 <= q_data.v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && rd_v_s1) begin
			out_item.y0_out <= g0_s1;
			out_item.u_out <= u_s1;
			out_item.y1_out <= g1_s1;
			out_item.v_out <= v_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (take_pix) rd_v_s1 <= 1'b1;
			else if (adv) rd_v_s1 <= 1'b0;
			if (adv) out_v_q <= rd_v_s1;
		end
	end

endmodule
